// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for checkers clocked by i_clk and reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ptm_pkg.sv -----
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, codes and default sizes of the paged memory unit.
// ----------------------------------------------------------------------------
package ptm_pkg;

    // default sizes
    localparam int PAGE_BYTES_DEF    = 16;
    localparam int NUM_FRAMES_DEF    = 4;
    localparam int NUM_PROCESSES_DEF = 4;
    localparam int TABLE_ENTRIES_DEF = 4;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int PROC_NUM_W = 2;
    localparam int VA_W      = 6;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 4;
    localparam int PADDR_W   = 6;
    localparam int FRAME_NUM_W = 2;
    localparam int VPAGE_W   = 2;

    localparam int ENTRY_BYTES = 4;
    localparam logic [BYTE_W-1:0] ENT_ST_EMPTY   = 8'd0;
    localparam logic [BYTE_W-1:0] ENT_ST_PRESENT = 8'd1;

    // byte offsets inside a table entry
    localparam logic [1:0] ENT_STATUS = 2'd0;
    localparam logic [1:0] ENT_VPAGE  = 2'd1;
    localparam logic [1:0] ENT_FRAME  = 2'd2;
    localparam logic [1:0] ENT_WRITE  = 2'd3;

    // operation codes; the fourth code is served as a load
    localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOAD_OK         = 4'd0,
        ST_STORE_OK        = 4'd1,
        ST_MAPPED          = 4'd2,
        ST_PERM_UPDATED    = 4'd3,
        ST_SAME_PERM       = 4'd4,
        ST_NO_TABLE        = 4'd5,
        ST_NO_MAPPING      = 4'd6,
        ST_WRITE_PROTECTED = 4'd7,
        ST_OUT_OF_MEMORY   = 4'd8,
        ST_BAD_MAP_VALUE   = 4'd9
    } t_status;

    typedef struct packed {
        logic [FRAME_NUM_W-1:0] frame;
        logic [PADDR_W-1:0]     paddr;
        logic [BYTE_W-1:0]      read_data;
        t_status                status;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_STAT,
        S_CHK_STAT,
        S_CHK_VP,
        S_GOT_FRM,
        S_GOT_PERM,
        S_LOAD_DATA,
        S_SCAN_END,
        S_WR_ENT,
        S_RESULT
    } t_state;

endpackage

// ----- rtl/ptm_mem.sv -----
// ----------------------------------------------------------------------------
// ptm_mem
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ptm_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ptm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptm_ctrl
// Request sequencer: walks the page table byte by byte through a single
// byte comparator, allocates frames and updates the byte memory.
// ----------------------------------------------------------------------------
module ptm_ctrl #(
    parameter int PAGE_BYTES    = 16,
    parameter int NUM_FRAMES    = 4,
    parameter int NUM_PROCESSES = 4,
    parameter int TABLE_ENTRIES = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ptm_pkg::OP_W-1:0]   i_op,
    input  logic [ptm_pkg::PROC_NUM_W-1:0] i_proc,
    input  logic [ptm_pkg::VA_W-1:0]   i_va,
    input  logic [ptm_pkg::BYTE_W-1:0] i_val,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output ptm_pkg::t_result           o_res
);

    import ptm_pkg::*;

    localparam int MEM_BYTES    = PAGE_BYTES * NUM_FRAMES;
    localparam int ADDR_W       = $clog2(MEM_BYTES);
    localparam int SLOTS        = PAGE_BYTES / ENTRY_BYTES;
    localparam int USED_ENTRIES = (TABLE_ENTRIES < SLOTS) ? TABLE_ENTRIES : SLOTS;
    localparam int SLOT_W       = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int FRAME_W      = $clog2(NUM_FRAMES);
    localparam int PROC_W       = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int VPAGE_MAX    = (2**VA_W - 1) / PAGE_BYTES;

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op;
    logic [PROC_NUM_W-1:0]  r_proc;
    logic [VA_W-1:0]        r_va;
    logic [BYTE_W-1:0]      r_val;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic                   r_empty_found, n_empty_found;
    logic [SLOT_W-1:0]      r_empty_slot, n_empty_slot;
    logic [BYTE_W-1:0]      r_fb, n_fb;
    logic [FRAME_W-1:0]     r_new_frame, n_new_frame;
    logic [1:0]             r_byte_idx, n_byte_idx;
    logic [ADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic [NUM_FRAMES-1:0]  r_in_use, n_in_use;
    logic [NUM_PROCESSES-1:0] r_tbl_valid, n_tbl_valid;
    logic [FRAME_W-1:0]     r_tbl_idx [NUM_PROCESSES];
    logic [FRAME_W-1:0]     n_tbl_idx [NUM_PROCESSES];
    t_result                r_res, n_res;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [BYTE_W-1:0]      mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [BYTE_W-1:0]      mem_rdata;

    logic [VPAGE_W-1:0]     vpage;
    logic [VA_W-1:0]        offset;
    logic [PROC_W-1:0]      pidx;
    logic                   proc_ok;
    logic                   is_map, is_store;
    logic [ADDR_W-1:0]      ent_base;
    logic [ADDR_W-1:0]      phys;
    logic [NUM_FRAMES-1:0]  free, free_low;
    logic                   free_any;
    logic [FRAME_W-1:0]     free_idx;
    logic [BYTE_W-1:0]      cmp_b;
    logic                   cmp_eq;
    logic                   slot_last;

    ptm_mem #(
        .DEPTH  (MEM_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // page and offset of the virtual address, by compares against page bounds
    always_comb begin
        vpage = '0;
        for (int k = 1; k <= VPAGE_MAX; k++) begin
            vpage = vpage + VPAGE_W'(r_va >= VA_W'(k * PAGE_BYTES));
        end
        offset = r_va - VA_W'(int'(vpage) * PAGE_BYTES);
    end

    assign pidx     = PROC_W'(r_proc);
    assign proc_ok  = int'(r_proc) < NUM_PROCESSES;
    assign is_map   = (r_op == OP_MAP);
    assign is_store = (r_op == OP_STORE);
    assign ent_base = ADDR_W'(int'(r_tbl_idx[pidx]) * PAGE_BYTES)
                    + ADDR_W'(int'(r_slot) * ENTRY_BYTES);
    assign phys     = ADDR_W'(int'(r_fb[FRAME_W-1:0]) * PAGE_BYTES) + ADDR_W'(offset);
    assign slot_last = (r_slot == SLOT_W'(USED_ENTRIES - 1));

    // lowest free frame: isolate the lowest set bit, then encode it
    always_comb begin
        free     = ~r_in_use;
        free_low = free & (~free + NUM_FRAMES'(1));
        free_any = |free;
        free_idx = '0;
        for (int f = 0; f < NUM_FRAMES; f++) begin
            if (free_low[f]) begin
                free_idx = free_idx | FRAME_W'(f);
            end
        end
    end

    // shared byte comparator on the memory read data
    always_comb begin
        case (r_state)
            S_CHK_VP:   cmp_b = BYTE_W'(vpage);
            S_GOT_PERM: cmp_b = is_map ? r_val : ENT_ST_EMPTY;
            default:    cmp_b = ENT_ST_EMPTY;
        endcase
        cmp_eq = (mem_rdata == cmp_b);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (is_map) begin
                    if (r_val > 8'd1 || !proc_ok) begin
                        n_state = S_RESULT;
                    end else if (!r_tbl_valid[pidx] && !free_any) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_RD_STAT;
                    end
                end else if (!proc_ok || !r_tbl_valid[pidx]) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_RD_STAT;
                end
            end
            S_RD_STAT: n_state = S_CHK_STAT;
            S_CHK_STAT: begin
                if (!cmp_eq) begin
                    n_state = S_CHK_VP;
                end else begin
                    n_state = slot_last ? S_SCAN_END : S_RD_STAT;
                end
            end
            S_CHK_VP: begin
                if (cmp_eq) begin
                    n_state = S_GOT_FRM;
                end else begin
                    n_state = slot_last ? S_SCAN_END : S_RD_STAT;
                end
            end
            S_GOT_FRM:  n_state = S_GOT_PERM;
            S_GOT_PERM: n_state = (is_map || is_store) ? S_RESULT : S_LOAD_DATA;
            S_LOAD_DATA: n_state = S_RESULT;
            S_SCAN_END: begin
                if (is_map && r_empty_found && free_any) begin
                    n_state = S_WR_ENT;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_WR_ENT: begin
                if (r_byte_idx == ENT_WRITE) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_slot        = r_slot;
        n_empty_found = r_empty_found;
        n_empty_slot  = r_empty_slot;
        n_fb          = r_fb;
        n_new_frame   = r_new_frame;
        n_byte_idx    = r_byte_idx;
        n_clr_addr    = r_clr_addr;
        n_in_use      = r_in_use;
        n_tbl_valid   = r_tbl_valid;
        n_tbl_idx     = r_tbl_idx;
        n_res         = r_res;
        mem_we        = 1'b0;
        mem_waddr     = ent_base;
        mem_wdata     = r_val;
        mem_raddr     = ent_base;
        o_in_ready    = 1'b0;
        o_res_valid   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_DECODE: begin
                n_slot        = '0;
                n_empty_found = 1'b0;
                n_res         = '{frame: '0, paddr: '0, read_data: '0, status: ST_NO_TABLE};
                if (is_map) begin
                    if (r_val > 8'd1) begin
                        n_res.status = ST_BAD_MAP_VALUE;
                    end else if (proc_ok && !r_tbl_valid[pidx]) begin
                        if (free_any) begin
                            n_in_use[free_idx] = 1'b1;
                            n_tbl_valid[pidx]  = 1'b1;
                            n_tbl_idx[pidx]    = free_idx;
                        end else begin
                            n_res.status = ST_OUT_OF_MEMORY;
                        end
                    end
                end
            end
            S_CHK_STAT: begin
                mem_raddr = ent_base + ADDR_W'(ENT_VPAGE);
                if (cmp_eq) begin
                    if (!r_empty_found) begin
                        n_empty_found = 1'b1;
                        n_empty_slot  = r_slot;
                    end
                    if (!slot_last) begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                end
            end
            S_CHK_VP: begin
                mem_raddr = ent_base + ADDR_W'(ENT_FRAME);
                if (!cmp_eq && !slot_last) begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            S_GOT_FRM: begin
                mem_raddr = ent_base + ADDR_W'(ENT_WRITE);
                n_fb      = mem_rdata;
            end
            S_GOT_PERM: begin
                mem_raddr = phys;
                if (is_map) begin
                    if (cmp_eq) begin
                        n_res.status = ST_SAME_PERM;
                    end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = ent_base + ADDR_W'(ENT_WRITE);
                        n_res.status = ST_PERM_UPDATED;
                        n_res.frame  = FRAME_NUM_W'(r_fb);
                    end
                end else if (is_store) begin
                    if (cmp_eq) begin
                        n_res.status = ST_WRITE_PROTECTED;
                    end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = phys;
                        n_res.status = ST_STORE_OK;
                        n_res.paddr  = PADDR_W'(phys);
                    end
                end
            end
            S_LOAD_DATA: begin
                n_res.status    = ST_LOAD_OK;
                n_res.read_data = mem_rdata;
                n_res.paddr     = PADDR_W'(phys);
            end
            S_SCAN_END: begin
                if (!is_map) begin
                    n_res.status = ST_NO_MAPPING;
                end else if (r_empty_found && free_any) begin
                    n_in_use[free_idx] = 1'b1;
                    n_new_frame        = free_idx;
                    n_slot             = r_empty_slot;
                    n_byte_idx         = ENT_STATUS;
                    n_res.status       = ST_MAPPED;
                    n_res.frame        = FRAME_NUM_W'(free_idx);
                end else begin
                    n_res.status = ST_OUT_OF_MEMORY;
                end
            end
            S_WR_ENT: begin
                mem_we     = 1'b1;
                mem_waddr  = ent_base + ADDR_W'(r_byte_idx);
                n_byte_idx = r_byte_idx + 2'd1;
                case (r_byte_idx)
                    ENT_STATUS: mem_wdata = ENT_ST_PRESENT;
                    ENT_VPAGE:  mem_wdata = BYTE_W'(vpage);
                    ENT_FRAME:  mem_wdata = BYTE_W'(r_new_frame);
                    default:    mem_wdata = r_val;
                endcase
            end
            S_RESULT: begin
                o_res_valid = i_res_ready;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_in_use    <= '0;
            r_tbl_valid <= '0;
            for (int p = 0; p < NUM_PROCESSES; p++) begin
                r_tbl_idx[p] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_in_use    <= n_in_use;
            r_tbl_valid <= n_tbl_valid;
            r_tbl_idx   <= n_tbl_idx;
        end
    end

    // request and scan payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op   <= i_op;
            r_proc <= i_proc;
            r_va   <= i_va;
            r_val  <= i_val;
        end
        r_slot        <= n_slot;
        r_empty_found <= n_empty_found;
        r_empty_slot  <= n_empty_slot;
        r_fb          <= n_fb;
        r_new_frame   <= n_new_frame;
        r_byte_idx    <= n_byte_idx;
        r_res         <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/page_table_mmu_map_load_store.sv -----
// ----------------------------------------------------------------------------
// page_table_mmu_map_load_store
// Paged byte memory with per-process one-level page tables (map/store/load).
// ----------------------------------------------------------------------------
// After reset the unit zeroes its byte memory, PAGE_BYTES*NUM_FRAMES bytes
// (64 by default), and holds s_axis_tready low meanwhile. It then serves one
// request at a time: it takes the transfer and decodes it, then reads and
// compares the status byte of each table slot that is checked, and the virtual
// page byte as well for each present one; a hit then fetches the frame and
// permission bytes and, for a load, the data byte, while a miss closes the
// scan and, for a new mapping, writes the four bytes of the entry; last, the
// result is handed over once the output side can take it.
// The single byte-wide read port of the memory paces the table walk: each
// table byte is fetched and compared separately. The result waits in an
// output register, so a stalled master side never loses a response.
module page_table_mmu_map_load_store #(
    parameter int PAGE_BYTES    = ptm_pkg::PAGE_BYTES_DEF,
    parameter int NUM_FRAMES    = ptm_pkg::NUM_FRAMES_DEF,
    parameter int NUM_PROCESSES = ptm_pkg::NUM_PROCESSES_DEF,
    parameter int TABLE_ENTRIES = ptm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] process number, [7:2] virtual byte address, [15:8] operand value
    input  logic [15:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] status, [11:4] read data, [17:12] translated address,
    // [19:18] frame, [23:20] zero
    output logic [23:0] m_axis_tdata
);

    import ptm_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign res_ready = !r_out_valid || m_axis_tready;

    ptm_ctrl #(
        .PAGE_BYTES    (PAGE_BYTES),
        .NUM_FRAMES    (NUM_FRAMES),
        .NUM_PROCESSES (NUM_PROCESSES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_proc      (s_axis_tdata[1:0]),
        .i_va        (s_axis_tdata[7:2]),
        .i_val       (s_axis_tdata[15:8]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register: load on a new result, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.frame, r_out.paddr, r_out.read_data,
                            r_out.status};

endmodule

// ----- rtl/ptm_checker.sv -----
// ----------------------------------------------------------------------------
// ptm_checker
// Port-level checks of the paged memory unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    import ptm_pkg::*;

    logic [3:0] st;
    logic       in_xfer;
    logic       addr_ok;
    logic       frame_ok;
    logic       out_stall;
    logic       fail_rsp;
    logic       other_rsp;

    assign st        = m_axis_tdata[3:0];
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign addr_ok   = (st == ST_LOAD_OK) || (st == ST_STORE_OK);
    assign frame_ok  = (st == ST_MAPPED) || (st == ST_PERM_UPDATED);
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign fail_rsp  = m_axis_tvalid && !addr_ok;
    assign other_rsp = m_axis_tvalid && !frame_ok;

    `ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_axis_tready, "ready held after a transfer")
    `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result changed")
    `ASSERT_SAME(a_no_addr_on_fail, fail_rsp, m_axis_tdata[17:4] == 14'd0, "data on a failure")
    `ASSERT_SAME(a_frame_only_on_map, other_rsp, m_axis_tdata[19:18] == 2'd0, "stray frame")

endmodule

bind page_table_mmu_map_load_store ptm_checker u_ptm_checker (.*);

// ----- verif/tb_page_table_mmu_map_load_store.sv -----
// ----------------------------------------------------------------------------
// tb_page_table_mmu_map_load_store
// Stream-level test of the paged memory unit. A shadow copy of the byte
// memory, the frame pool and the per-process table pointers predicts the
// response for every request accepted on the slave side. Each response on the
// master side is checked field by field against the oldest prediction. A
// directed sequence comes first: bad map values, missing tables, new
// mappings, permission changes, write protection, loads and stores. It then
// runs frame exhaustion, including a table that is built with no data frame
// left. Random traffic follows, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_page_table_mmu_map_load_store;
    import ptm_pkg::*;

    // both upper codes are served as loads
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD_HI = 2'd3;
    localparam int RANDOM_REQUESTS = 500;
    localparam int MAX_REPORTS     = 20;

    // shadow of the unit: predicts one response per request, checks responses
    class mmu_shadow;
        localparam int PAGE    = PAGE_BYTES_DEF;
        localparam int NFRAMES = NUM_FRAMES_DEF;
        localparam int NPROC   = NUM_PROCESSES_DEF;
        localparam int MEM     = PAGE * NFRAMES;
        localparam int SLOTS   = (TABLE_ENTRIES_DEF < PAGE / ENTRY_BYTES) ?
                                 TABLE_ENTRIES_DEF : PAGE / ENTRY_BYTES;

        logic [BYTE_W-1:0] mem_image [MEM];
        bit                frame_taken [NFRAMES];
        bit                tbl_valid [NPROC];
        int                tbl_frame [NPROC];
        t_result           awaited [$];
        int                fails;
        int                requests;
        int                checked;
        int                status_hits [10];

        function new();
            foreach (mem_image[i]) mem_image[i] = '0;
            foreach (frame_taken[i]) frame_taken[i] = 1'b0;
            foreach (tbl_valid[i]) begin
                tbl_valid[i] = 1'b0;
                tbl_frame[i] = 0;
            end
            foreach (status_hits[i]) status_hits[i] = 0;
            fails    = 0;
            requests = 0;
            checked  = 0;
        endfunction

        function logic [BYTE_W-1:0] rd(int a);
            return mem_image[a % MEM];
        endfunction

        function void wr(int a, logic [BYTE_W-1:0] v);
            mem_image[a % MEM] = v;
        endfunction

        function int free_frame();
            for (int f = 0; f < NFRAMES; f++)
                if (!frame_taken[f]) return f;
            return -1;
        endfunction

        function int entry_addr(int proc, int slot);
            return (tbl_frame[proc] * PAGE + slot * ENTRY_BYTES) % MEM;
        endfunction

        // address of the present entry for this page, or -1
        function int find_entry(int proc, int vpage);
            int b;
            for (int s = 0; s < SLOTS; s++) begin
                b = entry_addr(proc, s);
                if (rd(b) != ENT_ST_EMPTY && rd(b + 1) == vpage) return b;
            end
            return -1;
        endfunction

        function int empty_slot(int proc);
            int b;
            for (int s = 0; s < SLOTS; s++) begin
                b = entry_addr(proc, s);
                if (rd(b) == ENT_ST_EMPTY) return b;
            end
            return -1;
        endfunction

        function void predict_request(logic [OP_W-1:0] op, logic [PROC_NUM_W-1:0] proc,
                                      logic [VA_W-1:0] va, logic [BYTE_W-1:0] val);
            t_result r;
            int      vpage;
            int      off;
            int      e;
            int      f;
            int      slot;
            int      pa;
            r = '0;
            vpage = va / PAGE;
            off = va % PAGE;
            requests++;
            if (op == OP_MAP) begin
                if (val > 1) begin
                    r.status = ST_BAD_MAP_VALUE;
                end else if (proc >= NPROC) begin
                    r.status = ST_NO_TABLE;
                end else begin
                    r.status = ST_MAPPED;
                    if (!tbl_valid[proc]) begin
                        f = free_frame();
                        if (f < 0) begin
                            r.status = ST_OUT_OF_MEMORY;
                        end else begin
                            frame_taken[f] = 1'b1;
                            tbl_valid[proc] = 1'b1;
                            tbl_frame[proc] = f;
                        end
                    end
                    if (r.status == ST_MAPPED) begin
                        e = find_entry(proc, vpage);
                        if (e >= 0) begin
                            if (rd(e + 3) == val) begin
                                r.status = ST_SAME_PERM;
                            end else begin
                                wr(e + 3, val);
                                r.status = ST_PERM_UPDATED;
                                r.frame = FRAME_NUM_W'(rd(e + 2));
                            end
                        end else begin
                            slot = empty_slot(proc);
                            f = free_frame();
                            if (slot < 0 || f < 0) begin
                                r.status = ST_OUT_OF_MEMORY;
                            end else begin
                                frame_taken[f] = 1'b1;
                                wr(slot, ENT_ST_PRESENT);
                                wr(slot + 1, BYTE_W'(vpage));
                                wr(slot + 2, BYTE_W'(f));
                                wr(slot + 3, val);
                                r.frame = FRAME_NUM_W'(f);
                            end
                        end
                    end
                end
            end else if (proc >= NPROC || !tbl_valid[proc]) begin
                r.status = ST_NO_TABLE;
            end else begin
                e = find_entry(proc, vpage);
                if (e < 0) begin
                    r.status = ST_NO_MAPPING;
                end else begin
                    pa = (int'(rd(e + 2)) * PAGE + off) % MEM;
                    if (op == OP_STORE) begin
                        if (rd(e + 3) == 0) begin
                            r.status = ST_WRITE_PROTECTED;
                        end else begin
                            mem_image[pa] = val;
                            r.status = ST_STORE_OK;
                            r.paddr = PADDR_W'(pa);
                        end
                    end else begin
                        r.status = ST_LOAD_OK;
                        r.read_data = mem_image[pa];
                        r.paddr = PADDR_W'(pa);
                    end
                end
            end
            awaited.push_back(r);
        endfunction

        task report(string msg);
            if (fails < MAX_REPORTS) $display("MISMATCH: %s", msg);
            fails++;
        endtask

        task check_result(logic [23:0] d);
            t_result got;
            t_result want;
            got = t_result'(d[19:0]);
            if (awaited.size() == 0) begin
                report($sformatf("response %h with no request pending", d));
                return;
            end
            want = awaited.pop_front();
            checked++;
            status_hits[want.status]++;
            if (got.status != want.status)
                report($sformatf("resp %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            if (got.read_data != want.read_data)
                report($sformatf("resp %0d read data %h, want %h",
                                 checked, got.read_data, want.read_data));
            if (got.paddr != want.paddr)
                report($sformatf("resp %0d translated address %h, want %h",
                                 checked, got.paddr, want.paddr));
            if (got.frame != want.frame)
                report($sformatf("resp %0d frame %0d, want %0d",
                                 checked, got.frame, want.frame));
            if (d[23:20] != 4'd0)
                report($sformatf("resp %0d pad bits %h not zero", checked, d[23:20]));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    bit          steady = 1'b0;
    mmu_shadow   sb = new();

    page_table_mmu_map_load_store uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stall the master side about a third of the time outside the steady stretch
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // hold the request until the transfer, then note it in the shadow
    task automatic send_request(input logic [OP_W-1:0] op, input logic [PROC_NUM_W-1:0] proc,
                                input logic [VA_W-1:0] va, input logic [BYTE_W-1:0] val);
        while (!steady && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, va, proc};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_request(op, proc, va, val);
    endtask

    initial begin
        logic [OP_W-1:0]       op;
        logic [PROC_NUM_W-1:0] proc;
        logic [VA_W-1:0]       va;
        logic [BYTE_W-1:0]     val;
        int                    pick;
        int                    directed;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing allocated yet, and map values out of range
        send_request(OP_LOAD,    2'd0, 6'h00, 8'h00);
        send_request(OP_STORE,   2'd3, 6'h3F, 8'hFF);
        send_request(OP_MAP,     2'd0, 6'h10, 8'd2);
        send_request(OP_MAP,     2'd1, 6'h3F, 8'hFF);
        send_request(OP_LOAD_HI, 2'd2, 6'h25, 8'h00);
        // first map builds the table, then a read-only page
        send_request(OP_MAP,     2'd0, 6'h15, 8'd0);
        send_request(OP_STORE,   2'd0, 6'h15, 8'hAA);
        send_request(OP_LOAD,    2'd0, 6'h2A, 8'h00);
        send_request(OP_MAP,     2'd0, 6'h1F, 8'd0);
        send_request(OP_MAP,     2'd0, 6'h10, 8'd1);
        send_request(OP_STORE,   2'd0, 6'h1F, 8'hFF);
        send_request(OP_STORE,   2'd0, 6'h10, 8'h00);
        send_request(OP_LOAD_HI, 2'd0, 6'h1F, 8'h00);
        send_request(OP_LOAD,    2'd0, 6'h10, 8'h00);
        send_request(OP_MAP,     2'd0, 6'h2C, 8'd1);
        send_request(OP_STORE,   2'd0, 6'h20, 8'h5A);
        send_request(OP_LOAD,    2'd0, 6'h2F, 8'h00);
        // last frame goes to a new table, leaving no data frame
        send_request(OP_MAP,     2'd1, 6'h3F, 8'd1);
        send_request(OP_STORE,   2'd1, 6'h3F, 8'h11);
        send_request(OP_MAP,     2'd2, 6'h00, 8'd0);
        send_request(OP_MAP,     2'd1, 6'h00, 8'd0);
        send_request(OP_MAP,     2'd0, 6'h30, 8'd1);
        send_request(OP_LOAD,    2'd3, 6'h3F, 8'h00);
        directed = sb.requests;

        // mostly traffic on the mapped process, the rest anywhere
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            steady = (n >= 200 && n < 300);
            pick = $urandom_range(99);
            op = (pick < 20) ? OP_MAP : (pick < 60) ? OP_STORE :
                 (pick < 90) ? OP_LOAD : OP_LOAD_HI;
            proc = ($urandom_range(9) < 7) ? 2'd0 : PROC_NUM_W'($urandom_range(3));
            va = VA_W'($urandom);
            if (op == OP_MAP && $urandom_range(99) < 85) val = BYTE_W'($urandom_range(1));
            else val = BYTE_W'($urandom);
            send_request(op, proc, va, val);
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d requests (%0d directed), checked %0d responses, %0d mismatches.",
                 sb.requests, directed, sb.checked, sb.fails);
        $display({"Status mix: load %0d store %0d mapped %0d perm %0d same %0d",
                  " notbl %0d nomap %0d wp %0d oom %0d bad %0d"},
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 sb.status_hits[3], sb.status_hits[4], sb.status_hits[5],
                 sb.status_hits[6], sb.status_hits[7], sb.status_hits[8],
                 sb.status_hits[9]);
        if (sb.fails == 0) begin
            $display("** page_table_mmu_map_load_store: PASSED **");
        end else begin
            $display("** page_table_mmu_map_load_store: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d responses outstanding.", sb.awaited.size());
        $display("** page_table_mmu_map_load_store: FAILED **");
        $finish;
    end

endmodule

// ----- page_table_mmu_map_load_store.f -----
+incdir+rtl
rtl/ptm_pkg.sv
rtl/ptm_mem.sv
rtl/ptm_ctrl.sv
rtl/page_table_mmu_map_load_store.sv
rtl/ptm_checker.sv
verif/tb_page_table_mmu_map_load_store.sv
